[sv/ssrf_pkg.sv]
// ----------------------------------------------------------------------------
// ssrf_pkg
// Shared types and constants for the stereo sample ring FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package ssrf_pkg;

    localparam int DEF_RING_DEPTH   = 8192;
    localparam int DEF_CHUNK_FRAMES = 64;

    localparam int SAMPLE_W    = 16;
    localparam int FRAME_W     = 2 * SAMPLE_W;
    localparam int FILL_W      = 13;
    localparam int COUNT_W     = 32;
    localparam int REQ_W       = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 160;

    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PULL   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REPORT = 2'd2;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHUNK,
        ST_REPORT
    } ctrl_state_t;

    typedef struct packed {
        logic push;
        logic flush;
        logic pull_start;
        logic frame_issue;
        logic report_issue;
    } ctl_cmd_t;

    typedef struct packed {
        logic issue_ok;
        logic chunk_last;
    } dp_status_t;

    typedef struct packed {
        logic                      kind;
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic                      last;
        logic [FILL_W-1:0]         fill_level;
        logic [COUNT_W-1:0]        underrun_count;
        logic [COUNT_W-1:0]        dropped_count;
        logic [COUNT_W-1:0]        written_count;
        logic [FILL_W-1:0]         low_fill;
    } out_item_t;

endpackage

`default_nettype wire

[sv/ssrf_ctrl.sv]
// ----------------------------------------------------------------------------
// ssrf_ctrl
// Request decode and sequencing of chunk and report transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrf_ctrl
    import ssrf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire logic [REQ_W-1:0] req_type,
    input  wire logic             req_mute,
    input  wire dp_status_t       status,
    output ctl_cmd_t              cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    if (req_type == REQ_PULL && !req_mute) begin
                        state_next = ST_CHUNK;
                    end else if (req_type == REQ_REPORT) begin
                        state_next = ST_REPORT;
                    end
                end
            end
            ST_CHUNK: begin
                if (status.issue_ok && status.chunk_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (status.issue_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        req_ready = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    case (req_type)
                        REQ_PUSH: begin
                            cmd.push = 1'b1;
                        end
                        REQ_PULL: begin
                            cmd.flush      = req_mute;
                            cmd.pull_start = !req_mute;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CHUNK: begin
                cmd.frame_issue = status.issue_ok;
            end
            ST_REPORT: begin
                cmd.report_issue = status.issue_ok;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/ssrf_datapath.sv]
// ----------------------------------------------------------------------------
// ssrf_datapath
// Frame memory, ring pointers, statistics and the two-entry output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrf_datapath
    import ssrf_pkg::*;
#(
    parameter int RING_DEPTH   = DEF_RING_DEPTH,
    parameter int CHUNK_FRAMES = DEF_CHUNK_FRAMES
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire ctl_cmd_t                   cmd,
    output dp_status_t                      status,
    input  wire logic signed [SAMPLE_W-1:0] wr_left,
    input  wire logic signed [SAMPLE_W-1:0] wr_right,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output out_item_t                       out_item
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(CHUNK_FRAMES + 1);
    localparam int CMP_W = (PTR_W > CNT_W) ? PTR_W : CNT_W;

    logic [FRAME_W-1:0] mem [RING_DEPTH];
    logic [FRAME_W-1:0] mem_rd_reg;

    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [COUNT_W-1:0] underruns_reg, underruns_next;
    logic [COUNT_W-1:0] drops_reg, drops_next;
    logic [COUNT_W-1:0] accepted_reg, accepted_next;
    logic [PTR_W-1:0]   low_reg, low_next;
    logic               low_valid_reg, low_valid_next;
    logic [CNT_W-1:0]   take_reg, take_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_mem_reg, s1_mem_next;
    out_item_t          s1_item_reg, s1_item_next;

    out_item_t          ent0_reg, ent0_next;
    out_item_t          ent1_reg, ent1_next;
    logic [1:0]         count_reg, count_next;

    logic [PTR_W-1:0]   wptr_inc, rptr_inc;
    logic [PTR_W:0]     fill_sum;
    logic [PTR_W-1:0]   fill;
    logic               full;
    logic [CMP_W-1:0]   fill_cmp;
    logic [CNT_W-1:0]   take;
    logic               frame_from_mem;
    logic [PTR_W+FILL_W-1:0] fill_wide;
    logic [PTR_W+FILL_W-1:0] low_wide;
    logic               pop;
    logic [2:0]         occupancy;
    logic [1:0]         push_pos;
    out_item_t          push_item;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_comb begin
        wptr_inc = ptr_inc(wptr_reg);
        rptr_inc = ptr_inc(rptr_reg);
        if (wptr_reg >= rptr_reg) begin
            fill_sum = {1'b0, wptr_reg} - {1'b0, rptr_reg};
        end else begin
            fill_sum = (PTR_W+1)'(RING_DEPTH) + {1'b0, wptr_reg} - {1'b0, rptr_reg};
        end
        fill      = fill_sum[PTR_W-1:0];
        full      = (wptr_inc == rptr_reg);
        fill_cmp  = CMP_W'(fill);
        if (fill_cmp < CMP_W'(CHUNK_FRAMES)) begin
            take = CNT_W'(fill);
        end else begin
            take = CNT_W'(CHUNK_FRAMES);
        end
        fill_wide = {{FILL_W{1'b0}}, fill};
        low_wide  = {{FILL_W{1'b0}}, low_reg};
        frame_from_mem = (idx_reg < take_reg);
    end

    // Credit check: the output buffer must have room when the staged item lands.
    always_comb begin
        pop       = out_valid && out_ready;
        occupancy = {1'b0, count_reg} + {2'b00, s1_valid_reg};
        status.issue_ok   = (occupancy <= (3'd1 + {2'b00, pop}));
        status.chunk_last = (idx_reg == CNT_W'(CHUNK_FRAMES - 1));
    end

    always_comb begin
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        underruns_next = underruns_reg;
        drops_next     = drops_reg;
        accepted_next  = accepted_reg;
        low_next       = low_reg;
        low_valid_next = low_valid_reg;
        take_next      = take_reg;
        idx_next       = idx_reg;
        s1_valid_next  = cmd.frame_issue || cmd.report_issue;
        s1_mem_next    = 1'b0;
        s1_item_next   = '0;

        if (cmd.push) begin
            if (full) begin
                drops_next = drops_reg + COUNT_W'(1);
            end else begin
                wptr_next     = wptr_inc;
                accepted_next = accepted_reg + COUNT_W'(1);
            end
        end

        if (cmd.flush) begin
            rptr_next = wptr_reg;
        end

        if (cmd.pull_start) begin
            if (!low_valid_reg || fill < low_reg) begin
                low_next       = fill;
                low_valid_next = 1'b1;
            end
            take_next = take;
            idx_next  = '0;
            if (take != CNT_W'(CHUNK_FRAMES)) begin
                underruns_next = underruns_reg + COUNT_W'(1);
            end
        end

        if (cmd.frame_issue) begin
            s1_item_next.kind = KIND_FRAME;
            s1_item_next.last = status.chunk_last;
            s1_mem_next       = frame_from_mem;
            idx_next          = idx_reg + CNT_W'(1);
            if (frame_from_mem) begin
                rptr_next = rptr_inc;
            end
        end

        if (cmd.report_issue) begin
            s1_item_next.kind           = KIND_REPORT;
            s1_item_next.last           = 1'b1;
            s1_item_next.fill_level     = fill_wide[FILL_W-1:0];
            s1_item_next.underrun_count = underruns_reg;
            s1_item_next.dropped_count  = drops_reg;
            s1_item_next.written_count  = accepted_reg;
            s1_item_next.low_fill       = low_valid_reg ? low_wide[FILL_W-1:0] : '0;
            low_next                    = '0;
            low_valid_next              = 1'b0;
        end
    end

    always_comb begin
        push_item = s1_item_reg;
        if (s1_mem_reg) begin
            push_item.out_left  = mem_rd_reg[SAMPLE_W-1:0];
            push_item.out_right = mem_rd_reg[FRAME_W-1:SAMPLE_W];
        end
        push_pos   = count_reg - {1'b0, pop};
        count_next = count_reg + {1'b0, s1_valid_reg} - {1'b0, pop};
        ent0_next  = pop ? ent1_reg : ent0_reg;
        ent1_next  = ent1_reg;
        if (s1_valid_reg && push_pos == 2'd0) begin
            ent0_next = push_item;
        end
        if (s1_valid_reg && push_pos == 2'd1) begin
            ent1_next = push_item;
        end
        out_valid = (count_reg != 2'd0);
        out_item  = ent0_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.push && !full) begin
            mem[wptr_reg] <= {wr_right, wr_left};
        end
        if (cmd.frame_issue && frame_from_mem) begin
            mem_rd_reg <= mem[rptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            underruns_reg <= '0;
            drops_reg     <= '0;
            accepted_reg  <= '0;
            low_reg       <= '0;
            low_valid_reg <= 1'b0;
            take_reg      <= '0;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            count_reg     <= '0;
        end else begin
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            underruns_reg <= underruns_next;
            drops_reg     <= drops_next;
            accepted_reg  <= accepted_next;
            low_reg       <= low_next;
            low_valid_reg <= low_valid_next;
            take_reg      <= take_next;
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_mem_reg  <= s1_mem_next;
        s1_item_reg <= s1_item_next;
        ent0_reg    <= ent0_next;
        ent1_reg    <= ent1_next;
    end

endmodule

`default_nettype wire

[sv/stereo_sample_ring_fifo.sv]
// ----------------------------------------------------------------------------
// stereo_sample_ring_fifo
// Ring FIFO of stereo frames with drop on full, zero padding on short pulls,
// muted flush and statistics reports.
// ----------------------------------------------------------------------------
// Push: one transaction per cycle while no pull or report is in progress, no output.
// Pull: input busy until the whole chunk is issued; frames leave one per cycle
//   through the single-port frame memory read while the output buffer has room.
// Report: input busy until the item is issued; it passes through the staging register.
// Reset (aresetn low, synchronous): pointers, counters and control cleared;
//   frame memory contents are not cleared.
`default_nettype none

module stereo_sample_ring_fifo
    import ssrf_pkg::*;
#(
    parameter int RING_DEPTH   = DEF_RING_DEPTH,
    parameter int CHUNK_FRAMES = DEF_CHUNK_FRAMES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // left_sample, right_sample, mute
    input  wire logic [REQ_W-1:0]     s_axis_tuser,  // req_type
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,  // out_left, out_right, fill_level,
                                                     // underrun_count, dropped_count,
                                                     // written_count, low_fill
    output logic                      m_axis_tlast,
    output logic [0:0]                m_axis_tuser   // kind
);

    ctl_cmd_t   cmd;
    dp_status_t status;
    out_item_t  item;

    ssrf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req_type  (s_axis_tuser),
        .req_mute  (s_axis_tdata[2*SAMPLE_W]),
        .status    (status),
        .cmd       (cmd)
    );

    ssrf_datapath #(
        .RING_DEPTH   (RING_DEPTH),
        .CHUNK_FRAMES (CHUNK_FRAMES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .wr_left   (s_axis_tdata[SAMPLE_W-1:0]),
        .wr_right  (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (item)
    );

    assign m_axis_tdata = {6'd0, item.low_fill, item.written_count, item.dropped_count,
                           item.underrun_count, item.fill_level, item.out_right,
                           item.out_left};
    assign m_axis_tlast = item.last;
    assign m_axis_tuser = item.kind;

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo sample ring FIFO: a clocked driver feeds
// queued requests, a clocked monitor checks every output transaction against a
// ring mirror that predicts chunks, padding, drops, flushes and reports.
// ----------------------------------------------------------------------------

module tb_top;
    import ssrf_pkg::*;

    localparam int RING         = DEF_RING_DEPTH;
    localparam int CHUNK        = DEF_CHUNK_FRAMES;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [REQ_W-1:0]           req;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       mute;
        bit                         drain;
    } ring_request_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [REQ_W-1:0]     s_axis_tuser  = REQ_PUSH;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic [0:0]           m_axis_tuser;

    ring_request_t pending[$];
    ring_request_t offered;
    out_item_t     expected_items[$];

    int src_idle_pct  = 12;
    int sink_idle_pct = 80;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int errors        = 0;
    int cycle_count   = 0;

    // ring mirror
    logic [FRAME_W-1:0] mirror_store[RING];
    int                 mirror_wr;
    int                 mirror_rd;
    logic [COUNT_W-1:0] mirror_underruns;
    logic [COUNT_W-1:0] mirror_drops;
    logic [COUNT_W-1:0] mirror_accepted;
    int                 mirror_low;
    bit                 mirror_low_valid;

    stereo_sample_ring_fifo i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 aclk = ~aclk;

    function automatic int ring_fill();
        return (mirror_wr + RING - mirror_rd) % RING;
    endfunction

    task automatic predict_ring_request(input ring_request_t r);
        int        fill;
        int        take;
        out_item_t e;
        fill = ring_fill();
        case (r.req)
            REQ_PUSH: begin
                if (fill >= RING - 1) begin
                    mirror_drops++;
                end else begin
                    mirror_store[mirror_wr] = {r.right, r.left};
                    mirror_wr = (mirror_wr + 1) % RING;
                    mirror_accepted++;
                end
            end
            REQ_PULL: begin
                if (r.mute) begin
                    mirror_rd = mirror_wr;
                end else begin
                    if (!mirror_low_valid || fill < mirror_low) begin
                        mirror_low = fill;
                        mirror_low_valid = 1'b1;
                    end
                    take = (fill < CHUNK) ? fill : CHUNK;
                    if (take < CHUNK) mirror_underruns++;
                    for (int k = 0; k < CHUNK; k++) begin
                        e = '0;
                        e.kind = KIND_FRAME;
                        if (k < take) begin
                            {e.out_right, e.out_left} = mirror_store[mirror_rd];
                            mirror_rd = (mirror_rd + 1) % RING;
                        end
                        e.last = (k == CHUNK - 1);
                        expected_items.push_back(e);
                    end
                end
            end
            REQ_REPORT: begin
                e = '0;
                e.kind           = KIND_REPORT;
                e.last           = 1'b1;
                e.fill_level     = fill[FILL_W-1:0];
                e.underrun_count = mirror_underruns;
                e.dropped_count  = mirror_drops;
                e.written_count  = mirror_accepted;
                e.low_fill       = mirror_low_valid ? mirror_low[FILL_W-1:0] : '0;
                expected_items.push_back(e);
                mirror_low       = 0;
                mirror_low_valid = 1'b0;
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge aclk) begin
        bit            busy;
        ring_request_t nxt;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            busy = s_axis_tvalid && !s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) predict_ring_request(offered);
            if (!busy) begin
                if (pending.size() > 0 && !(pending[0].drain && expected_items.size() != 0)
                        && $urandom_range(99) >= src_idle_pct) begin
                    nxt = pending.pop_front();
                    offered = nxt;
                    s_axis_tdata  <= {7'b0, nxt.mute, nxt.right, nxt.left};
                    s_axis_tuser  <= nxt.req;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink backpressure
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // monitor
    always @(posedge aclk) begin
        out_item_t got;
        out_item_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.kind           = m_axis_tuser[0];
            got.out_left       = m_axis_tdata[15:0];
            got.out_right      = m_axis_tdata[31:16];
            got.last           = m_axis_tlast;
            got.fill_level     = m_axis_tdata[44:32];
            got.underrun_count = m_axis_tdata[76:45];
            got.dropped_count  = m_axis_tdata[108:77];
            got.written_count  = m_axis_tdata[140:109];
            got.low_fill       = m_axis_tdata[153:141];
            if (expected_items.size() == 0) begin
                errors++;
                $display("%0t unexpected transaction: expected none, actual %h",
                         $time, got);
            end else begin
                want = expected_items.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("out_left", want.out_left, got.out_left);
                check_field("out_right", want.out_right, got.out_right);
                check_field("last", want.last, got.last);
                check_field("fill_level", want.fill_level, got.fill_level);
                check_field("underrun_count", want.underrun_count, got.underrun_count);
                check_field("dropped_count", want.dropped_count, got.dropped_count);
                check_field("written_count", want.written_count, got.written_count);
                check_field("low_fill", want.low_fill, got.low_fill);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_request(input logic [REQ_W-1:0] req, input logic [15:0] l,
                               input logic [15:0] r, input logic mute, input bit drain);
        ring_request_t q;
        q.req   = req;
        q.left  = l;
        q.right = r;
        q.mute  = mute;
        q.drain = drain;
        pending.push_back(q);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_push(input int n);
        repeat (n) add_request(REQ_PUSH, rand_sample(), rand_sample(), 1'($urandom), 1'b0);
    endtask

    task automatic add_random(input int target);
        int added;
        int burst;
        int sel;
        added = 0;
        while (added < target) begin
            burst = ($urandom_range(2) == 0) ? $urandom_range(70) : $urandom_range(6);
            add_push(burst);
            sel = $urandom_range(99);
            if (sel < 60) begin
                add_request(REQ_PULL, rand_sample(), rand_sample(),
                            ($urandom_range(7) == 0), ($urandom_range(9) == 0));
            end else if (sel < 90) begin
                add_request(REQ_REPORT, rand_sample(), rand_sample(), 1'($urandom), 1'b0);
            end else begin
                add_request(REQ_UNUSED, rand_sample(), rand_sample(), 1'($urandom), 1'b0);
            end
            added += burst + 1;
        end
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || s_axis_tvalid || expected_items.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        mirror_wr        = 0;
        mirror_rd        = 0;
        mirror_underruns = '0;
        mirror_drops     = '0;
        mirror_accepted  = '0;
        mirror_low       = 0;
        mirror_low_valid = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty ring, sample extremes, ignored mute and code, flushes
        add_request(REQ_REPORT, 16'h0000, 16'h0000, 1'b0, 1'b0);
        add_request(REQ_PULL,   16'h0000, 16'h0000, 1'b0, 1'b0);
        add_request(REQ_PUSH,   16'h8000, 16'h7FFF, 1'b0, 1'b0);
        add_request(REQ_PUSH,   16'h7FFF, 16'h8000, 1'b1, 1'b0);
        add_request(REQ_PUSH,   16'h0000, 16'hFFFF, 1'b0, 1'b0);
        add_request(REQ_PUSH,   16'hFFFF, 16'h0000, 1'b1, 1'b0);
        add_request(REQ_PUSH,   16'h5555, 16'hAAAA, 1'b0, 1'b0);
        add_request(REQ_PUSH,   16'hAAAA, 16'h5555, 1'b0, 1'b0);
        add_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        add_request(REQ_REPORT, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        add_request(REQ_PULL,   16'h1234, 16'h4321, 1'b0, 1'b0);
        add_request(REQ_REPORT, 16'h0000, 16'h0000, 1'b0, 1'b0);
        add_push(3);
        add_request(REQ_PULL,   16'h0000, 16'h0000, 1'b1, 1'b0);
        add_request(REQ_REPORT, 16'h0000, 16'h0000, 1'b0, 1'b0);
        add_request(REQ_PULL,   16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        add_request(REQ_PULL,   16'h0000, 16'h0000, 1'b0, 1'b0);
        add_request(REQ_REPORT, 16'h0000, 16'h0000, 1'b0, 1'b0);
        add_random(40);
        wait_drained();

        src_idle_pct  = 80;
        sink_idle_pct = 12;
        add_random(20);
        wait_drained();
        // stall the output long enough to back up a chunk into the input
        hold_token++;
        add_push(12);
        add_request(REQ_PULL, 16'h0000, 16'h0000, 1'b0, 1'b0);
        add_push(30);
        add_request(REQ_REPORT, 16'h0000, 16'h0000, 1'b0, 1'b0);
        add_request(REQ_PULL, 16'h0000, 16'h0000, 1'b0, 1'b0);
        add_push(5);
        add_request(REQ_REPORT, 16'h0000, 16'h0000, 1'b0, 1'b1);
        add_random(20);
        wait_drained();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // flush, then a back-to-back push burst ahead of a short, padded chunk
        add_request(REQ_PULL, 16'h0000, 16'h0000, 1'b1, 1'b1);
        add_push(40);
        add_request(REQ_REPORT, 16'h0000, 16'h0000, 1'b0, 1'b0);
        add_request(REQ_PULL,   16'h0000, 16'h0000, 1'b0, 1'b0);
        add_push(2);
        add_request(REQ_REPORT, 16'h0000, 16'h0000, 1'b0, 1'b0);
        add_request(REQ_PULL,   16'h0000, 16'h0000, 1'b1, 1'b0);
        add_request(REQ_REPORT, 16'h0000, 16'h0000, 1'b0, 1'b0);
        add_random(40);
        wait_drained();

        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
